// ===== hw/rtl/scancode_set1_to_ascii_top_macros.svh =====
// Assertion macros for the set-1 scancode decoder.
// Used by scancode_set1_to_ascii_top; no other dependencies.
`ifndef SCANCODE_SET1_TO_ASCII_TOP_MACROS_SVH
`define SCANCODE_SET1_TO_ASCII_TOP_MACROS_SVH

// same-cycle implication
`define SC1A_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sc1a same-cycle check failed");

// next-cycle implication
`define SC1A_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sc1a next-cycle check failed");

`endif

// ===== hw/rtl/sc1a_pkg.sv =====
// Package for the set-1 scancode decoder: widths, key codes, kinds and
// the US-layout character tables. No dependencies.
`timescale 1ns / 1ps

package sc1a_pkg;

  localparam int IN_W   = 8;
  localparam int OUT_W  = 16;
  localparam int USER_W = 4;
  localparam int TAB_N  = 58;
  localparam int KEY_N  = 128;

  localparam logic [7:0] SC_PREFIX  = 8'hE0;
  localparam logic [6:0] KC_SHIFT_L = 7'h2A;
  localparam logic [6:0] KC_SHIFT_R = 7'h36;
  localparam logic [6:0] KC_CTRL    = 7'h1D;
  localparam logic [6:0] KC_ALT     = 7'h38;
  localparam logic [6:0] KC_CAPS    = 7'h3A;
  localparam logic [6:0] KC_NUM     = 7'h45;
  localparam logic [6:0] KC_LEFT    = 7'h4B;
  localparam logic [6:0] KC_RIGHT   = 7'h4D;
  localparam logic [6:0] KC_UP      = 7'h48;
  localparam logic [6:0] KC_DOWN    = 7'h50;
  localparam logic [6:0] KC_HOME    = 7'h47;
  localparam logic [6:0] KC_END     = 7'h4F;
  localparam logic [6:0] KC_DELETE  = 7'h53;

  localparam logic [2:0] KIND_CHAR   = 3'd0;
  localparam logic [2:0] KIND_LEFT   = 3'd1;
  localparam logic [2:0] KIND_RIGHT  = 3'd2;
  localparam logic [2:0] KIND_UP     = 3'd3;
  localparam logic [2:0] KIND_DOWN   = 3'd4;
  localparam logic [2:0] KIND_HOME   = 3'd5;
  localparam logic [2:0] KIND_END    = 3'd6;
  localparam logic [2:0] KIND_DELETE = 3'd7;

  localparam logic [6:0] CH_LOWER_A = 7'h61;
  localparam logic [6:0] CH_LOWER_Z = 7'h7A;
  localparam logic [6:0] CH_CTRL_OFS = 7'h60;

  localparam logic [6:0] PLAIN_TAB [TAB_N] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B,
    7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C,
    7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C,
    7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  localparam logic [6:0] SHIFT_TAB [TAB_N] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B,
    7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C,
    7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C,
    7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  function automatic logic [6:0] tab_lookup(input logic [6:0] code, input logic shifted);
    logic [6:0] ch;
    ch = 7'h00;
    if (!code[6] && (code[5:0] < 6'(TAB_N))) begin
      ch = shifted ? SHIFT_TAB[code[5:0]] : PLAIN_TAB[code[5:0]];
    end
    return ch;
  endfunction

  function automatic logic [2:0] ext_kind(input logic [6:0] code);
    logic [2:0] k;
    case (code)
      KC_LEFT:   k = KIND_LEFT;
      KC_RIGHT:  k = KIND_RIGHT;
      KC_UP:     k = KIND_UP;
      KC_DOWN:   k = KIND_DOWN;
      KC_HOME:   k = KIND_HOME;
      KC_END:    k = KIND_END;
      KC_DELETE: k = KIND_DELETE;
      default:   k = KIND_CHAR;
    endcase
    return k;
  endfunction

endpackage

// ===== hw/rtl/scancode_set1_to_ascii_top.sv =====
// Each scancode passes through the input register, then the result register, before m_tvalid.
// Throughput: one scancode per cycle; one result per scancode, stalls on m_tready and during the reset clearing pass.
// The pressed-map bit is read from memory into the input register at the transfer.
// Reset (rst, synchronous): clears prefix flag, modifiers and both valid flags; then a
// pass over all 128 addresses clears the pressed map while s_tready stays low.
// Depends on sc1a_pkg and scancode_set1_to_ascii_top_macros.svh.
`timescale 1ns / 1ps
`include "scancode_set1_to_ascii_top_macros.svh"

module scancode_set1_to_ascii_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [sc1a_pkg::IN_W-1:0]    s_tdata,  // [7:0] scancode
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [6:0] char_code, [7] shift_held, [8] ctrl_held, [9] alt_held,
  // [10] caps_on, [11] num_on, [15:12] zero
  output logic [sc1a_pkg::OUT_W-1:0]   m_tdata,
  output logic [sc1a_pkg::USER_W-1:0]  m_tuser   // [0] key_valid, [3:1] key_kind
);
  import sc1a_pkg::*;

  logic            in_valid;
  logic [IN_W-1:0] in_data;
  logic            advance;

  logic       map_mem [KEY_N];
  logic       map_rd;
  logic       clearing;
  logic [6:0] clr_addr;

  logic shift_flag, ctrl_flag, alt_flag, caps_toggle, num_toggle, ext_pending;
  logic shift_next, ctrl_next, alt_next, caps_next, num_next, ext_next;

  logic       map_we;
  logic       map_val;
  logic [6:0] code;
  logic       brk;
  logic       down;
  logic       apply;
  logic       key_valid;
  logic [2:0] key_kind;
  logic [6:0] char_code;
  logic [6:0] base;
  logic       is_letter;
  logic       shift_sel;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !clearing && (!in_valid || advance);
  assign code     = in_data[6:0];
  assign brk      = in_data[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 7'd1;
      if (clr_addr == 7'h7F) begin
        clearing <= 1'b0;
      end
    end
  end

  // pressed map; the bit of the item in flight is forwarded on a same-key transfer
  always_ff @(posedge clk) begin
    if (clearing) begin
      map_mem[clr_addr] <= 1'b0;
    end else if (advance && map_we) begin
      map_mem[code] <= map_val;
    end
    if (s_tready && s_tvalid) begin
      if (advance && map_we && (code == s_tdata[6:0])) begin
        map_rd <= map_val;
      end else begin
        map_rd <= map_mem[s_tdata[6:0]];
      end
    end
  end

  always_comb begin
    shift_next = shift_flag;
    ctrl_next  = ctrl_flag;
    alt_next   = alt_flag;
    caps_next  = caps_toggle;
    num_next   = num_toggle;
    ext_next   = ext_pending;
    map_we     = 1'b0;
    map_val    = 1'b0;
    key_valid  = 1'b0;
    key_kind   = KIND_CHAR;
    char_code  = 7'h00;
    apply      = 1'b0;
    down       = 1'b0;
    base       = tab_lookup(code, 1'b0);
    is_letter  = base inside {[CH_LOWER_A:CH_LOWER_Z]};
    shift_sel  = shift_flag ^ (caps_toggle && is_letter);

    if (in_data == SC_PREFIX) begin
      ext_next = 1'b1;
    end else if (ext_pending) begin
      ext_next = 1'b0;
      if (!brk) begin
        key_kind  = ext_kind(code);
        key_valid = (key_kind != KIND_CHAR);
      end
    end else if (brk) begin
      if (map_rd) begin
        map_we = 1'b1;
        apply  = 1'b1;
      end
    end else begin
      map_we  = 1'b1;
      map_val = 1'b1;
      apply   = 1'b1;
      down    = 1'b1;
    end

    if (apply) begin
      case (code)
        KC_SHIFT_L, KC_SHIFT_R: shift_next = down;
        KC_CTRL:                ctrl_next  = down;
        KC_ALT:                 alt_next   = down;
        KC_CAPS:                caps_next  = caps_toggle ^ down;
        KC_NUM:                 num_next   = num_toggle ^ down;
        default: begin
          if (down) begin
            if (ctrl_flag) begin
              char_code = is_letter ? (base - CH_CTRL_OFS) : 7'h00;
            end else begin
              char_code = shift_sel ? tab_lookup(code, 1'b1) : base;
            end
            key_valid = (char_code != 7'h00);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_flag  <= 1'b0;
      ctrl_flag   <= 1'b0;
      alt_flag    <= 1'b0;
      caps_toggle <= 1'b0;
      num_toggle  <= 1'b0;
      ext_pending <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (advance) begin
        shift_flag  <= shift_next;
        ctrl_flag   <= ctrl_next;
        alt_flag    <= alt_next;
        caps_toggle <= caps_next;
        num_toggle  <= num_next;
        ext_pending <= ext_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (advance) begin
      m_tdata <= {4'h0, num_next, caps_next, alt_next, ctrl_next, shift_next, char_code};
      m_tuser <= {key_kind, key_valid};
    end
  end

  `SC1A_ASSERT_IMP(a_valid_has_key, clk, rst, m_tvalid && m_tuser[0], m_tuser[3:1] != KIND_CHAR || m_tdata[6:0] != 7'h00)
  `SC1A_ASSERT_IMP(a_kind_no_char, clk, rst, m_tvalid && (m_tuser[3:1] != KIND_CHAR), m_tdata[6:0] == 7'h00)
  `SC1A_ASSERT_IMP(a_ctrl_letter, clk, rst, m_tvalid && m_tuser[0] && m_tdata[8] && (m_tuser[3:1] == KIND_CHAR), m_tdata[6:0] <= 7'd26)
  `SC1A_ASSERT_NXT(a_prefix_arms, clk, rst, advance && (in_data == SC_PREFIX), ext_pending && !m_tuser[0])
  `SC1A_ASSERT_IMP(a_clear_blocks, clk, rst, clearing, !s_tready)

endmodule

// ===== tb/tb_scancode_set1_to_ascii_top.sv =====
// Testbench for scancode_set1_to_ascii_top: drives set-1 scancode bytes with random gaps
// and stalls, predicts each result in a local decoder model and checks every field.
// Depends on sc1a_pkg and the RTL of scancode_set1_to_ascii_top.
`timescale 1ns / 1ps

module tb_scancode_set1_to_ascii_top;
  import sc1a_pkg::*;

  typedef struct packed {
    logic       num_on;
    logic       caps_on;
    logic       alt_held;
    logic       ctrl_held;
    logic       shift_held;
    logic [6:0] char_code;
    logic [2:0] key_kind;
    logic       key_valid;
  } key_result_t;

  localparam int         MAP_N    = 58;
  localparam logic [6:0] LETTER_A = 7'h61;
  localparam logic [6:0] LETTER_Z = 7'h7A;

  localparam logic [6:0] US_PLAIN [MAP_N] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B,
    7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C,
    7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C,
    7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  localparam logic [6:0] US_SHIFTED [MAP_N] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B,
    7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C,
    7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C,
    7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata;   // [7:0] scancode
  logic              m_tvalid;
  logic              m_tready;
  // [6:0] char_code, [7] shift_held, [8] ctrl_held, [9] alt_held,
  // [10] caps_on, [11] num_on, [15:12] zero
  logic [OUT_W-1:0]  m_tdata;
  logic [USER_W-1:0] m_tuser;   // [0] key_valid, [3:1] key_kind

  scancode_set1_to_ascii_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // decoder model state
  bit held_map [128];
  bit shift_f, ctrl_f, alt_f, caps_f, num_f, prefix_armed;

  key_result_t pending_keys [$];
  int          mismatches;
  bit          idle_on;
  int          stall_left;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic key_result_t decode_scancode(input logic [7:0] sc);
    key_result_t r;
    logic [6:0]  code;
    logic [6:0]  base;
    bit          shift_sel;
    code = sc[6:0];
    r = '0;
    if (sc == SC_PREFIX) begin
      prefix_armed = 1'b1;
    end else if (prefix_armed) begin
      prefix_armed = 1'b0;
      if (!sc[7]) begin
        case (code)
          KC_LEFT:   r.key_kind = KIND_LEFT;
          KC_RIGHT:  r.key_kind = KIND_RIGHT;
          KC_UP:     r.key_kind = KIND_UP;
          KC_DOWN:   r.key_kind = KIND_DOWN;
          KC_HOME:   r.key_kind = KIND_HOME;
          KC_END:    r.key_kind = KIND_END;
          KC_DELETE: r.key_kind = KIND_DELETE;
          default:   r.key_kind = KIND_CHAR;
        endcase
        r.key_valid = (r.key_kind != KIND_CHAR);
      end
    end else if (sc[7]) begin
      if (held_map[code]) begin
        held_map[code] = 1'b0;
        case (code)
          KC_SHIFT_L, KC_SHIFT_R: shift_f = 1'b0;
          KC_CTRL:                ctrl_f = 1'b0;
          KC_ALT:                 alt_f = 1'b0;
          default: ;
        endcase
      end
    end else begin
      held_map[code] = 1'b1;
      case (code)
        KC_SHIFT_L, KC_SHIFT_R: shift_f = 1'b1;
        KC_CTRL:                ctrl_f = 1'b1;
        KC_ALT:                 alt_f = 1'b1;
        KC_CAPS:                caps_f = ~caps_f;
        KC_NUM:                 num_f = ~num_f;
        default: begin
          base = (code < MAP_N) ? US_PLAIN[code] : 7'h00;
          if (ctrl_f) begin
            if (base >= LETTER_A && base <= LETTER_Z) r.char_code = base - LETTER_A + 7'd1;
          end else begin
            shift_sel = shift_f ^ (caps_f && base >= LETTER_A && base <= LETTER_Z);
            if (shift_sel) r.char_code = (code < MAP_N) ? US_SHIFTED[code] : 7'h00;
            else r.char_code = base;
          end
          r.key_valid = (r.char_code != 7'h00);
        end
      endcase
    end
    r.shift_held = shift_f;
    r.ctrl_held  = ctrl_f;
    r.alt_held   = alt_f;
    r.caps_on    = caps_f;
    r.num_on     = num_f;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_code(input logic [7:0] sc);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sc;
    do @(posedge clk); while (!s_tready);
    pending_keys.push_back(decode_scancode(sc));
  endtask

  // result side: random stalls, checked at the rising edge
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < 25) begin
      stall_left = pick_gap();
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    key_result_t exp_r;
    key_result_t got_r;
    logic [6:0]  exp_f [8];
    logic [6:0]  got_f [8];
    string       names [8];
    if (!rst && m_tvalid && m_tready) begin
      got_r = {m_tdata[11:0], m_tuser};
      if (pending_keys.size() == 0) begin
        $error("result transfer with nothing expected: %h %h", m_tdata, m_tuser);
        mismatches++;
      end else begin
        exp_r = pending_keys.pop_front();
        names = '{"key_valid", "key_kind", "char_code", "shift_held",
                  "ctrl_held", "alt_held", "caps_on", "num_on"};
        exp_f = '{exp_r.key_valid, exp_r.key_kind, exp_r.char_code, exp_r.shift_held,
                  exp_r.ctrl_held, exp_r.alt_held, exp_r.caps_on, exp_r.num_on};
        got_f = '{got_r.key_valid, got_r.key_kind, got_r.char_code, got_r.shift_held,
                  got_r.ctrl_held, got_r.alt_held, got_r.caps_on, got_r.num_on};
        foreach (names[i]) begin
          if (got_f[i] !== exp_f[i]) begin
            $error("%s expected %0h got %0h", names[i], exp_f[i], got_f[i]);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic test_plain_and_shift();
    // code 0 is unmapped; releasing one shift clears it even with the other held
    send_code(8'h00);
    send_code(8'h1E);
    send_code({1'b0, KC_SHIFT_L});
    send_code(8'h1E);
    send_code(8'h02);
    send_code({1'b0, KC_SHIFT_R});
    send_code({1'b1, KC_SHIFT_L});
    send_code(8'h1E);
    send_code({1'b1, KC_SHIFT_R});
  endtask

  task automatic test_caps_and_num();
    send_code({1'b0, KC_CAPS});
    send_code(8'h1E);
    send_code(8'h02);
    send_code({1'b0, KC_SHIFT_L});
    send_code(8'h1E);
    send_code({1'b1, KC_SHIFT_L});
    send_code({1'b1, KC_CAPS});
    send_code({1'b0, KC_NUM});
  endtask

  task automatic test_ctrl_and_alt();
    send_code({1'b0, KC_CTRL});
    send_code(8'h2C);
    send_code(8'h02);
    send_code({1'b1, KC_CTRL});
    send_code({1'b0, KC_ALT});
    send_code({1'b1, KC_ALT});
  endtask

  task automatic test_extended_keys();
    // repeated prefix stays armed; break or unknown code after prefix gives nothing
    send_code(SC_PREFIX);
    send_code(SC_PREFIX);
    send_code({1'b0, KC_LEFT});
    send_code(SC_PREFIX);
    send_code({1'b1, KC_LEFT});
    send_code(SC_PREFIX);
    send_code(8'h1E);
  endtask

  task automatic test_unpressed_break();
    send_code(8'hFF);
    send_code(8'h7F);
    send_code(8'hFF);
  endtask

  task automatic test_random_typing(input int n_items);
    logic [6:0] nav_keys [7];
    logic [6:0] mod_keys [6];
    logic [6:0] code;
    int         sent;
    int         pick;
    nav_keys = '{KC_LEFT, KC_RIGHT, KC_UP, KC_DOWN, KC_HOME, KC_END, KC_DELETE};
    mod_keys = '{KC_SHIFT_L, KC_SHIFT_R, KC_CTRL, KC_ALT, KC_CAPS, KC_NUM};
    sent = 0;
    while (sent < n_items) begin
      idle_on = ((sent / 200) % 3) != 1;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        code = $urandom_range(1, MAP_N - 1);
        send_code({1'b0, code});
        sent++;
        if ($urandom_range(0, 9) < 8) begin
          send_code({1'b1, code});
          sent++;
        end
      end else if (pick < 55) begin
        code = mod_keys[$urandom_range(0, 5)];
        send_code({$urandom_range(0, 1) == 1, code});
        sent++;
      end else if (pick < 70) begin
        send_code(SC_PREFIX);
        if ($urandom_range(0, 3) != 0) code = nav_keys[$urandom_range(0, 6)];
        else code = $urandom_range(0, 127);
        send_code({$urandom_range(0, 9) < 3, code});
        sent += 2;
      end else if (pick < 85) begin
        send_code({1'b1, 7'($urandom_range(0, 127))});
        sent++;
      end else begin
        send_code(8'($urandom_range(0, 255)));
        sent++;
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    m_tready     = 1'b0;
    mismatches   = 0;
    idle_on      = 1'b1;
    stall_left   = 0;
    shift_f      = 1'b0;
    ctrl_f       = 1'b0;
    alt_f        = 1'b0;
    caps_f       = 1'b0;
    num_f        = 1'b0;
    prefix_armed = 1'b0;
    foreach (held_map[i]) held_map[i] = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_plain_and_shift();
    test_caps_and_num();
    test_ctrl_and_alt();
    test_extended_keys();
    test_unpressed_break();
    test_random_typing(1600);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
